// ===== design/rmrb_pkg.sv =====
// Shared constants, types and codes for the rename map and reorder buffer.
`timescale 1ns / 1ps

package rmrb_pkg;

    // Buffer geometry; ROB_DEPTH is kept a power of two so tags wrap by truncation
    localparam int ROB_DEPTH = 64;
    localparam int TAG_W     = $clog2(ROB_DEPTH);
    localparam int CNT_W     = $clog2(ROB_DEPTH + 1);
    localparam int ARCH_REGS = 67;
    localparam int AREG_W    = $clog2(ARCH_REGS);
    localparam int MAX_WIDTH = 8;
    localparam int RW_W      = $clog2(MAX_WIDTH + 1);

    // Field widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int REG_W    = 7;
    localparam int VAL_W    = 7;
    localparam int PC_W     = 64;
    localparam int CAP_W    = 7;
    localparam int WID_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;

    localparam logic [CAP_W-1:0] CAP_RESET   = 7'd64;
    localparam logic [WID_W-1:0] WIDTH_RESET = 4'd4;

    localparam logic [CMD_W-1:0] CMD_RENAME   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RETIRE   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROB_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETIRE_WIDTH = 2'd1;

    typedef struct packed {
        logic [PC_W-1:0]  pc;
        logic             dest_used;
        logic [REG_W-1:0] dest_reg;
    } rob_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REN_LOOK,
        ST_REN_SRC2,
        ST_REN_RDY2,
        ST_REN_COMMIT,
        ST_SINGLE,
        ST_RET_READ,
        ST_RET_CHECK,
        ST_RET_MAP
    } state_t;

endpackage

// ===== design/rmrb_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module rmrb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rename_map_reorder_buffer.sv =====
// Rename map and circular reorder buffer with a one-item-at-a-time sequencer.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_tvalid / s_tready  | s_tuser command, s_tdata operands
//  m_      | out       | m_tvalid / m_tready  | m_tuser status, m_tdata answers, m_tlast
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Complete and unknown commands answer directly; a rename first looks up both sources;
// every store sits in a single-read-port RAM, so the map and ready lookups run in turn.
// A retire reads the head and checks it; each pop then reads the map and the next head.
// aresetn is synchronous: map valid bits, pointers and occupancy clear, buffer RAMs do not.
// A result waits in the output register; the sequencer stalls only when it must load
// another word while that register is still full.
`timescale 1ns / 1ps

module rename_map_reorder_buffer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // src1_reg, src1_used, src2_reg, src2_used, dest_reg, dest_used, fetch_pc,
    // complete_tag, zero pad
    input  logic [rmrb_pkg::IN_DATA_W-1:0]    s_tdata,
    // command
    input  logic [rmrb_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // src1_value, src1_ready, src2_value, src2_ready, dest_tag, retired_tag,
    // retired_pc, retired_dest_reg, retired_dest_used, zero pad
    output logic [rmrb_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status
    output logic [rmrb_pkg::STAT_W-1:0]       m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rmrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rmrb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int TAG_W  = rmrb_pkg::TAG_W;
    localparam int CNT_W  = rmrb_pkg::CNT_W;
    localparam int AREG_W = rmrb_pkg::AREG_W;
    localparam int REG_W  = rmrb_pkg::REG_W;
    localparam int VAL_W  = rmrb_pkg::VAL_W;
    localparam int PC_W   = rmrb_pkg::PC_W;
    localparam int RW_W   = rmrb_pkg::RW_W;
    localparam int ENT_W  = $bits(rmrb_pkg::rob_entry_t);

    rmrb_pkg::state_t state_reg, state_next;

    logic [rmrb_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [rmrb_pkg::WID_W-1:0] width_reg, width_next;
    logic [rmrb_pkg::ARCH_REGS-1:0] map_valid_reg, map_valid_next;
    logic [TAG_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [RW_W-1:0]  n_reg, n_next;

    // Item held while it is worked on
    logic [rmrb_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [REG_W-1:0] src1_num_reg, src1_num_next, src2_num_reg, src2_num_next;
    logic [REG_W-1:0] dest_num_reg, dest_num_next;
    logic src1_used_reg, src1_used_next, src2_used_reg, src2_used_next;
    logic dest_used_reg, dest_used_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [TAG_W-1:0] ctag_reg, ctag_next;

    logic [TAG_W-1:0] tag1_reg, tag1_next, tag2_reg, tag2_next;
    logic rdy1_reg, rdy1_next;
    logic [TAG_W-1:0] pend_tag_reg, pend_tag_next;
    rmrb_pkg::rob_entry_t pend_ent_reg, pend_ent_next;

    logic out_valid_reg, out_valid_next;
    logic [rmrb_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [rmrb_pkg::STAT_W-1:0] out_user_reg, out_user_next;
    logic out_last_reg, out_last_next;

    // RAM ports
    logic              map_we;
    logic [AREG_W-1:0] map_waddr, map_raddr;
    logic [TAG_W-1:0]  map_wdata, map_rdata;
    logic              rdy_we;
    logic [TAG_W-1:0]  rdy_waddr, rdy_raddr;
    logic [0:0]        rdy_wdata, rdy_rdata;
    logic              ent_we;
    logic [TAG_W-1:0]  ent_waddr, ent_raddr;
    logic [ENT_W-1:0]  ent_wdata, ent_rdata;
    rmrb_pkg::rob_entry_t ent_q, ent_new;

    logic [CNT_W-1:0] cap_eff;
    logic [RW_W-1:0]  width_eff;
    logic s_accept, out_free, is_full, more, cmpl_hit;
    logic src1_map, src2_map, dest_in, pend_in;
    logic [TAG_W-1:0] cmpl_off, head_inc, tail_inc;

    // Result fields for the word being loaded
    logic [rmrb_pkg::STAT_W-1:0] r_status;
    logic r_last;
    logic [VAL_W-1:0] r_s1v, r_s2v;
    logic r_s1r, r_s2r, r_rdu;
    logic [TAG_W-1:0] r_dtag, r_rtag;
    logic [PC_W-1:0]  r_rpc;
    logic [REG_W-1:0] r_rdr;
    logic out_load;

    rmrb_ram #(.DEPTH(rmrb_pkg::ARCH_REGS), .WIDTH(TAG_W)) u_map_ram (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    rmrb_ram #(.DEPTH(rmrb_pkg::ROB_DEPTH), .WIDTH(1)) u_rdy_ram (
        .aclk(aclk), .we(rdy_we), .waddr(rdy_waddr), .wdata(rdy_wdata),
        .raddr(rdy_raddr), .rdata(rdy_rdata)
    );

    rmrb_ram #(.DEPTH(rmrb_pkg::ROB_DEPTH), .WIDTH(ENT_W)) u_ent_ram (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    assign ent_q     = rmrb_pkg::rob_entry_t'(ent_rdata);
    assign ent_wdata = ENT_W'(ent_new);

    assign s_tready  = (state_reg == rmrb_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Clamp the registers into their working ranges
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CNT_W'(cap_reg) > CNT_W'(rmrb_pkg::ROB_DEPTH)) begin
            cap_eff = CNT_W'(rmrb_pkg::ROB_DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
        if (width_reg == '0) begin
            width_eff = RW_W'(1);
        end else if (RW_W'(width_reg) > RW_W'(rmrb_pkg::MAX_WIDTH)) begin
            width_eff = RW_W'(rmrb_pkg::MAX_WIDTH);
        end else begin
            width_eff = RW_W'(width_reg);
        end
    end

    assign is_full  = (occ_reg >= cap_eff);
    assign src1_map = src1_used_reg && (src1_num_reg < REG_W'(rmrb_pkg::ARCH_REGS))
                      && map_valid_reg[src1_num_reg[AREG_W-1:0]];
    assign src2_map = src2_used_reg && (src2_num_reg < REG_W'(rmrb_pkg::ARCH_REGS))
                      && map_valid_reg[src2_num_reg[AREG_W-1:0]];
    assign dest_in  = dest_used_reg && (dest_num_reg < REG_W'(rmrb_pkg::ARCH_REGS));
    assign pend_in  = pend_ent_reg.dest_used
                      && (pend_ent_reg.dest_reg < REG_W'(rmrb_pkg::ARCH_REGS));
    // Tag distance from head; depth is a power of two so the subtract wraps
    assign cmpl_off = ctag_reg - head_reg;
    assign cmpl_hit = (CNT_W'(cmpl_off) < occ_reg);
    assign head_inc = (head_reg == TAG_W'(rmrb_pkg::ROB_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == TAG_W'(rmrb_pkg::ROB_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign more     = (n_reg < width_eff) && (occ_reg != '0) && rdy_rdata[0];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rmrb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_tuser)
                        rmrb_pkg::CMD_RENAME: state_next = rmrb_pkg::ST_REN_LOOK;
                        rmrb_pkg::CMD_RETIRE: state_next = rmrb_pkg::ST_RET_READ;
                        default:              state_next = rmrb_pkg::ST_SINGLE;
                    endcase
                end
            end
            rmrb_pkg::ST_REN_LOOK: begin
                if (!is_full) begin
                    state_next = rmrb_pkg::ST_REN_SRC2;
                end else if (out_free) begin
                    state_next = rmrb_pkg::ST_IDLE;
                end
            end
            rmrb_pkg::ST_REN_SRC2:   state_next = rmrb_pkg::ST_REN_RDY2;
            rmrb_pkg::ST_REN_RDY2:   state_next = rmrb_pkg::ST_REN_COMMIT;
            rmrb_pkg::ST_REN_COMMIT: begin
                if (out_free) begin
                    state_next = rmrb_pkg::ST_IDLE;
                end
            end
            rmrb_pkg::ST_SINGLE: begin
                if (out_free) begin
                    state_next = rmrb_pkg::ST_IDLE;
                end
            end
            rmrb_pkg::ST_RET_READ:   state_next = rmrb_pkg::ST_RET_CHECK;
            rmrb_pkg::ST_RET_CHECK: begin
                if (more) begin
                    if (n_reg == '0 || out_free) begin
                        state_next = rmrb_pkg::ST_RET_MAP;
                    end
                end else if (out_free) begin
                    state_next = rmrb_pkg::ST_IDLE;
                end
            end
            rmrb_pkg::ST_RET_MAP:    state_next = rmrb_pkg::ST_RET_READ;
            default:                 state_next = rmrb_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and register updates
    always_comb begin
        cap_next       = cap_reg;
        width_next     = width_reg;
        map_valid_next = map_valid_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        n_next         = n_reg;
        cmd_next       = cmd_reg;
        src1_num_next  = src1_num_reg;
        src1_used_next = src1_used_reg;
        src2_num_next  = src2_num_reg;
        src2_used_next = src2_used_reg;
        dest_num_next  = dest_num_reg;
        dest_used_next = dest_used_reg;
        pc_next        = pc_reg;
        ctag_next      = ctag_reg;
        tag1_next      = tag1_reg;
        tag2_next      = tag2_reg;
        rdy1_next      = rdy1_reg;
        pend_tag_next  = pend_tag_reg;
        pend_ent_next  = pend_ent_reg;

        map_we    = 1'b0;
        map_waddr = dest_num_reg[AREG_W-1:0];
        map_wdata = tail_reg;
        map_raddr = '0;
        rdy_we    = 1'b0;
        rdy_waddr = tail_reg;
        rdy_wdata = 1'b0;
        rdy_raddr = head_reg;
        ent_we    = 1'b0;
        ent_waddr = tail_reg;
        ent_raddr = head_reg;
        ent_new.pc        = pc_reg;
        ent_new.dest_used = dest_used_reg;
        ent_new.dest_reg  = dest_used_reg ? dest_num_reg : '0;

        out_load = 1'b0;
        r_status = rmrb_pkg::STAT_DONE;
        r_last   = 1'b1;
        r_s1v    = '0;
        r_s1r    = 1'b0;
        r_s2v    = '0;
        r_s2r    = 1'b0;
        r_dtag   = '0;
        r_rtag   = '0;
        r_rpc    = '0;
        r_rdr    = '0;
        r_rdu    = 1'b0;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rmrb_pkg::CFG_ROB_CAPACITY: cap_next   = cfg_data[rmrb_pkg::CAP_W-1:0];
                rmrb_pkg::CFG_RETIRE_WIDTH: width_next = cfg_data[rmrb_pkg::WID_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            rmrb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    cmd_next       = s_tuser;
                    src1_num_next  = s_tdata[6:0];
                    src1_used_next = s_tdata[7];
                    src2_num_next  = s_tdata[14:8];
                    src2_used_next = s_tdata[15];
                    dest_num_next  = s_tdata[22:16];
                    dest_used_next = s_tdata[23];
                    pc_next        = s_tdata[87:24];
                    ctag_next      = s_tdata[93:88];
                    n_next         = '0;
                end
            end
            rmrb_pkg::ST_REN_LOOK: begin
                map_raddr = src1_num_reg[AREG_W-1:0];
                if (is_full && out_free) begin
                    out_load = 1'b1;
                    r_status = rmrb_pkg::STAT_FULL;
                end
            end
            rmrb_pkg::ST_REN_SRC2: begin
                tag1_next = map_rdata;
                rdy_raddr = map_rdata;
                map_raddr = src2_num_reg[AREG_W-1:0];
            end
            rmrb_pkg::ST_REN_RDY2: begin
                rdy1_next = rdy_rdata[0];
                tag2_next = map_rdata;
                rdy_raddr = map_rdata;
            end
            rmrb_pkg::ST_REN_COMMIT: begin
                rdy_raddr = tag2_reg;
                if (out_free) begin
                    out_load = 1'b1;
                    r_s1v  = src1_map ? VAL_W'(tag1_reg) : src1_num_reg;
                    r_s1r  = src1_map ? rdy1_reg : 1'b1;
                    r_s2v  = src2_map ? VAL_W'(tag2_reg) : src2_num_reg;
                    r_s2r  = src2_map ? rdy_rdata[0] : 1'b1;
                    r_dtag = tail_reg;
                    // allocate the tail entry, not ready
                    rdy_we = 1'b1;
                    ent_we = 1'b1;
                    if (dest_in) begin
                        map_we = 1'b1;
                        map_valid_next[dest_num_reg[AREG_W-1:0]] = 1'b1;
                    end
                    tail_next = tail_inc;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            rmrb_pkg::ST_SINGLE: begin
                rdy_waddr = ctag_reg;
                rdy_wdata = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    // mark ready only for an occupied entry
                    rdy_we = (cmd_reg == rmrb_pkg::CMD_COMPLETE) && cmpl_hit;
                end
            end
            rmrb_pkg::ST_RET_READ: begin
                rdy_raddr = head_reg;
                ent_raddr = head_reg;
            end
            rmrb_pkg::ST_RET_CHECK: begin
                rdy_raddr = head_reg;
                ent_raddr = head_reg;
                map_raddr = (ent_q.dest_reg < REG_W'(rmrb_pkg::ARCH_REGS))
                            ? ent_q.dest_reg[AREG_W-1:0] : '0;
                r_rtag = pend_tag_reg;
                r_rpc  = pend_ent_reg.pc;
                r_rdr  = pend_ent_reg.dest_reg;
                r_rdu  = pend_ent_reg.dest_used;
                if (more) begin
                    // flush the previous pop, known now not to be the last
                    if (n_reg == '0 || out_free) begin
                        out_load      = (n_reg != '0);
                        r_last        = 1'b0;
                        pend_tag_next = head_reg;
                        pend_ent_next = ent_q;
                    end
                end else if (out_free) begin
                    out_load = 1'b1;
                    if (n_reg == '0) begin
                        r_status = rmrb_pkg::STAT_EMPTY;
                        r_rtag   = '0;
                        r_rpc    = '0;
                        r_rdr    = '0;
                        r_rdu    = 1'b0;
                    end
                end
            end
            rmrb_pkg::ST_RET_MAP: begin
                // drop the mapping only if it still names this entry
                if (pend_in && map_valid_reg[pend_ent_reg.dest_reg[AREG_W-1:0]]
                        && map_rdata == pend_tag_reg) begin
                    map_valid_next[pend_ent_reg.dest_reg[AREG_W-1:0]] = 1'b0;
                end
                head_next = head_inc;
                occ_next  = occ_reg - 1'b1;
                n_next    = n_reg + 1'b1;
            end
            default: ;
        endcase

        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next  = out_load
                         ? {4'b0, r_rdu, r_rdr, r_rpc, r_rtag, r_dtag, r_s2r, r_s2v, r_s1r, r_s1v}
                         : out_data_reg;
        out_user_next  = out_load ? r_status : out_user_reg;
        out_last_next  = out_load ? r_last : out_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rmrb_pkg::ST_IDLE;
            cap_reg       <= rmrb_pkg::CAP_RESET;
            width_reg     <= rmrb_pkg::WIDTH_RESET;
            map_valid_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            width_reg     <= width_next;
            map_valid_reg <= map_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        src1_num_reg  <= src1_num_next;
        src1_used_reg <= src1_used_next;
        src2_num_reg  <= src2_num_next;
        src2_used_reg <= src2_used_next;
        dest_num_reg  <= dest_num_next;
        dest_used_reg <= dest_used_next;
        pc_reg        <= pc_next;
        ctag_reg      <= ctag_next;
        tag1_reg      <= tag1_next;
        tag2_reg      <= tag2_next;
        rdy1_reg      <= rdy1_next;
        pend_tag_reg  <= pend_tag_next;
        pend_ent_reg  <= pend_ent_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(rmrb_pkg::ROB_DEPTH))
        else $error("occupancy above buffer depth");

    a_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg == TAG_W'({1'b0, head_reg} + occ_reg))
        else $error("tail does not sit occupancy entries past head");

    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rmrb_pkg::ST_REN_COMMIT |-> occ_reg < cap_eff)
        else $error("rename allocating into a full buffer");

    a_pop_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rmrb_pkg::ST_RET_MAP |-> n_reg < width_eff)
        else $error("retire popping beyond its width");

endmodule
